// ===== src/aftc_pkg.sv =====
// ----------------------------------------------------------------------------
// aftc_pkg
// Shared types and constants for the six-plane box culling core: plane
// register packing, plane verdict flags and default widths.
// ----------------------------------------------------------------------------
package aftc_pkg;

   // default geometry widths
   localparam int DEFAULT_COORD_BITS       = 20;
   localparam int DEFAULT_NORMAL_FRAC_BITS = 12;

   // plane register layout
   localparam int PLANE_COUNT = 6;
   localparam int NFIELD_BITS = 14;
   localparam int DFIELD_BITS = 22;
   localparam int AXIS_COUNT  = 3;

   // configuration port
   localparam int CSR_IDX_W  = $clog2(PLANE_COUNT);
   localparam int CSR_DATA_W = 3 * NFIELD_BITS + DFIELD_BITS;

   // one packed plane: normal in the low bits, distance on top
   typedef struct packed {
      logic signed [DFIELD_BITS-1:0] d;
      logic signed [NFIELD_BITS-1:0] nz;
      logic signed [NFIELD_BITS-1:0] ny;
      logic signed [NFIELD_BITS-1:0] nx;
   } plane_type;

   // verdict of one plane against the current box
   typedef struct packed {
      logic zero_normal;
      logic rejects;
      logic not_inside;
   } plane_flags_type;

endpackage

// ===== src/aftc_box_stage.sv =====
// ----------------------------------------------------------------------------
// aftc_box_stage
// Input register for one box; derives corner sums, extents and the
// min-not-above-max check from the registered corners.
// ----------------------------------------------------------------------------
module aftc_box_stage #(
   parameter int COORD_BITS = aftc_pkg::DEFAULT_COORD_BITS,
   localparam int SUM_W = COORD_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] min_x,
   input  logic signed [COORD_BITS-1:0] min_y,
   input  logic signed [COORD_BITS-1:0] min_z,
   input  logic signed [COORD_BITS-1:0] max_x,
   input  logic signed [COORD_BITS-1:0] max_y,
   input  logic signed [COORD_BITS-1:0] max_z,
   output logic                         valid,
   output logic                         box_ok,
   output logic signed [SUM_W-1:0]      sum [3],
   output logic signed [SUM_W-1:0]      ext [3]
);

   logic                         valid_ff;
   logic signed [COORD_BITS-1:0] lo_ff [3];
   logic signed [COORD_BITS-1:0] hi_ff [3];

   // beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   // corner capture
   always_ff @(posedge clock) begin
      if (accept) begin
         lo_ff[0] <= min_x;
         lo_ff[1] <= min_y;
         lo_ff[2] <= min_z;
         hi_ff[0] <= max_x;
         hi_ff[1] <= max_y;
         hi_ff[2] <= max_z;
      end
   end

   // sums, extents and ordering check per axis
   always_comb begin
      box_ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         sum[a] = SUM_W'(lo_ff[a]) + SUM_W'(hi_ff[a]);
         ext[a] = SUM_W'(hi_ff[a]) - SUM_W'(lo_ff[a]);
         if (lo_ff[a] > hi_ff[a]) begin
            box_ok = 1'b0;
         end
      end
   end

   assign valid = valid_ff;

endmodule

// ===== src/aftc_plane_eval.sv =====
// ----------------------------------------------------------------------------
// aftc_plane_eval
// One plane test: registered normal products, then the exact center and
// radius sums and their sign checks.
// ----------------------------------------------------------------------------
module aftc_plane_eval #(
   parameter int COORD_BITS       = aftc_pkg::DEFAULT_COORD_BITS,
   parameter int NORMAL_FRAC_BITS = aftc_pkg::DEFAULT_NORMAL_FRAC_BITS,
   localparam int SUM_W = COORD_BITS + 1
) (
   input  logic                     clock,
   input  aftc_pkg::plane_type      plane,
   input  logic signed [SUM_W-1:0]  sum [3],
   input  logic signed [SUM_W-1:0]  ext [3],
   output aftc_pkg::plane_flags_type flags
);

   import aftc_pkg::*;

   localparam int MAG_W   = NFIELD_BITS + 1;
   localparam int PROD_W  = MAG_W + SUM_W;
   localparam int DTERM_W = DFIELD_BITS + NORMAL_FRAC_BITS + 1;
   localparam int TOP_W   = (PROD_W > DTERM_W) ? PROD_W : DTERM_W;
   localparam int ACC_W   = TOP_W + 3;

   logic signed [MAG_W-1:0]       n_wide [AXIS_COUNT];
   logic signed [MAG_W-1:0]       n_mag  [AXIS_COUNT];
   logic signed [PROD_W-1:0]      prod_in [AXIS_COUNT];
   logic signed [PROD_W-1:0]      prod_ff [AXIS_COUNT];
   logic signed [PROD_W-1:0]      rad_in  [AXIS_COUNT];
   logic signed [PROD_W-1:0]      rad_ff  [AXIS_COUNT];
   logic                          zero_in;
   logic                          zero_ff;
   logic signed [DFIELD_BITS-1:0] d_ff;
   logic signed [DTERM_W-1:0]     dterm;
   logic signed [ACC_W-1:0]       center;
   logic signed [ACC_W-1:0]       radius;
   logic signed [ACC_W-1:0]       reach_hi;
   logic signed [ACC_W-1:0]       reach_lo;

   // normal magnitudes and per-axis products
   always_comb begin
      n_wide[0] = MAG_W'(plane.nx);
      n_wide[1] = MAG_W'(plane.ny);
      n_wide[2] = MAG_W'(plane.nz);
      for (int a = 0; a < AXIS_COUNT; a++) begin
         n_mag[a]   = n_wide[a][MAG_W-1] ? -n_wide[a] : n_wide[a];
         prod_in[a] = PROD_W'(n_wide[a]) * PROD_W'(sum[a]);
         rad_in[a]  = PROD_W'(n_mag[a]) * PROD_W'(ext[a]);
      end
      zero_in = (plane.nx == '0) && (plane.ny == '0) && (plane.nz == '0);
   end

   // product register
   always_ff @(posedge clock) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         prod_ff[a] <= prod_in[a];
         rad_ff[a]  <= rad_in[a];
      end
      zero_ff <= zero_in;
      d_ff    <= plane.d;
   end

   // center and radius, distance scaled by two normal units
   always_comb begin
      dterm    = $signed({d_ff, {(NORMAL_FRAC_BITS + 1){1'b0}}});
      center   = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
                 + ACC_W'(dterm);
      radius   = ACC_W'(rad_ff[0]) + ACC_W'(rad_ff[1]) + ACC_W'(rad_ff[2]);
      reach_hi = center + radius;
      reach_lo = center - radius;
   end

   // sign checks, boundary counts as inside
   assign flags.zero_normal = zero_ff;
   assign flags.rejects     = reach_hi[ACC_W-1];
   assign flags.not_inside  = reach_lo[ACC_W-1];

endmodule

// ===== src/aabb_frustum_cull_test_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_core
// A box passes the input, product and result registers to its rsp_valid beat.
// Throughput: one box per cycle while busy is low; the normal multipliers
// are registered before the sum and sign stage, so every stage takes a box
// each cycle. Reset clears all planes to zero and drops rsp_valid; busy
// stays high through reset and until busy_ff clears. The receiver cannot stall.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_core #(
   parameter int COORD_BITS       = aftc_pkg::DEFAULT_COORD_BITS,
   parameter int NORMAL_FRAC_BITS = aftc_pkg::DEFAULT_NORMAL_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // box beat
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_box_min_x,
   input  logic signed [COORD_BITS-1:0]         req_box_min_y,
   input  logic signed [COORD_BITS-1:0]         req_box_min_z,
   input  logic signed [COORD_BITS-1:0]         req_box_max_x,
   input  logic signed [COORD_BITS-1:0]         req_box_max_y,
   input  logic signed [COORD_BITS-1:0]         req_box_max_z,
   // verdict beat
   output logic                                 rsp_valid,
   output logic                                 rsp_touches_view,
   output logic                                 rsp_fully_inside,
   output logic                                 rsp_box_ok,
   // plane registers
   input  logic                                 csr_write_en,
   input  logic [aftc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aftc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   import aftc_pkg::*;

   localparam int SUM_W = COORD_BITS + 1;

   logic                    busy_ff;
   logic                    accept;
   plane_type               plane_ff [PLANE_COUNT];
   logic                    box_valid;
   logic                    box_ok;
   logic signed [SUM_W-1:0] box_sum [AXIS_COUNT];
   logic signed [SUM_W-1:0] box_ext [AXIS_COUNT];
   plane_flags_type         flags [PLANE_COUNT];
   logic                    valid2_ff;
   logic                    ok2_ff;
   logic                    touch_in;
   logic                    inside_in;
   logic                    rsp_valid_ff;
   logic                    touch_ff;
   logic                    inside_ff;
   logic                    box_ok_ff;

   // busy through reset and until busy_ff clears
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;

   // plane registers, indexes past the last plane are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_ff[p] <= '0;
         end
      end else begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            if (csr_write_en && csr_index == CSR_IDX_W'(p)) begin
               plane_ff[p] <= csr_write_data;
            end
         end
      end
   end

   // input register
   aftc_box_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_box_stage (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .min_x  (req_box_min_x),
      .min_y  (req_box_min_y),
      .min_z  (req_box_min_z),
      .max_x  (req_box_max_x),
      .max_y  (req_box_max_y),
      .max_z  (req_box_max_z),
      .valid  (box_valid),
      .box_ok (box_ok),
      .sum    (box_sum),
      .ext    (box_ext)
   );

   // one evaluator per plane
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      aftc_plane_eval #(
         .COORD_BITS       (COORD_BITS),
         .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_plane_eval (
         .clock (clock),
         .plane (plane_ff[p]),
         .sum   (box_sum),
         .ext   (box_ext),
         .flags (flags[p])
      );
   end

   // product stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= box_valid;
      end
   end

   always_ff @(posedge clock) begin
      ok2_ff <= box_ok;
   end

   // planes in order: first zero normal or first rejection ends the test
   always_comb begin
      logic open;
      open      = 1'b1;
      touch_in  = 1'b1;
      inside_in = ok2_ff;
      if (ok2_ff) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            if (open) begin
               priority if (flags[p].zero_normal) begin
                  inside_in = 1'b0;
                  open      = 1'b0;
               end else if (flags[p].rejects) begin
                  touch_in  = 1'b0;
                  inside_in = 1'b0;
                  open      = 1'b0;
               end else if (flags[p].not_inside) begin
                  inside_in = 1'b0;
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      touch_ff  <= touch_in;
      inside_ff <= inside_in;
      box_ok_ff <= ok2_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touches_view = touch_ff;
   assign rsp_fully_inside = inside_ff;
   assign rsp_box_ok       = box_ok_ff;

   // every accepted box gives its verdict after the input, product and result registers
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted box produced no verdict");

   // no verdict without a box accepted ahead of it in the pipeline
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("verdict without an accepted box");

   // a bad box is never culled nor inside
   a_bad_box : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_box_ok) |-> (rsp_touches_view && !rsp_fully_inside))
      else $error("bad box verdict wrong");

   // inside implies touching and a good box
   a_inside_touch : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fully_inside) |-> (rsp_touches_view && rsp_box_ok))
      else $error("inside without touching");

endmodule

// ===== tb/cull_checker.sv =====
// ----------------------------------------------------------------------------
// cull_checker
// Watches the box, verdict and plane-register ports of the culling core.
// Keeps its own copy of the six planes, works out the verdict of every
// accepted box and compares it field by field with the verdict beats.
// ----------------------------------------------------------------------------
module cull_checker
   import aftc_pkg::*;
#(
   parameter int COORD_W = DEFAULT_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic signed [COORD_W-1:0]   req_box_min_x,
   input  logic signed [COORD_W-1:0]   req_box_min_y,
   input  logic signed [COORD_W-1:0]   req_box_min_z,
   input  logic signed [COORD_W-1:0]   req_box_max_x,
   input  logic signed [COORD_W-1:0]   req_box_max_y,
   input  logic signed [COORD_W-1:0]   req_box_max_z,
   input  logic                        rsp_valid,
   input  logic                        rsp_touches_view,
   input  logic                        rsp_fully_inside,
   input  logic                        rsp_box_ok,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data,
   output int                          pending,
   output int                          failures,
   output int                          checked,
   output int                          culled,
   output int                          contained
);
   timeunit 1ns;
   timeprecision 1ps;

   // distance is scaled by two and by the normal fraction
   localparam int D_SHIFT = DEFAULT_NORMAL_FRAC_BITS + 1;

   typedef struct packed {
      logic touches;
      logic in_all;
      logic ok;
   } verdict_type;

   plane_type   plane_reg [PLANE_COUNT];
   verdict_type verdict_q [$];

   // exact six-plane test of one box against the current planes
   function automatic verdict_type cull_verdict(input longint x0, input longint y0,
                                                input longint z0, input longint x1,
                                                input longint y1, input longint z1);
      longint      lo [3];
      longint      hi [3];
      longint      n [3];
      longint      c, r;
      plane_type   pl;
      verdict_type v;
      bit          stop;
      lo[0] = x0; lo[1] = y0; lo[2] = z0;
      hi[0] = x1; hi[1] = y1; hi[2] = z1;
      v = '{touches: 1'b1, in_all: 1'b1, ok: 1'b1};
      stop = 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (lo[a] > hi[a]) v.ok = 1'b0;
      end
      // inverted box: counts as touching, never inside
      if (!v.ok) begin
         v.in_all = 1'b0;
         return v;
      end
      for (int p = 0; p < PLANE_COUNT && !stop; p++) begin
         pl   = plane_reg[p];
         n[0] = longint'($signed(pl.nx));
         n[1] = longint'($signed(pl.ny));
         n[2] = longint'($signed(pl.nz));
         if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            // zero normal ends the test, box treated as touching
            v.in_all = 1'b0;
            stop     = 1'b1;
         end else begin
            c = longint'($signed(pl.d)) * (longint'(1) << D_SHIFT);
            r = 0;
            for (int a = 0; a < AXIS_COUNT; a++) begin
               c += n[a] * (lo[a] + hi[a]);
               r += ((n[a] < 0) ? -n[a] : n[a]) * (hi[a] - lo[a]);
            end
            if (c - r < 0) v.in_all = 1'b0;
            if (c + r < 0) begin
               v.touches = 1'b0;
               v.in_all  = 1'b0;
               stop      = 1'b1;
            end
         end
      end
      return v;
   endfunction

   // sample all ports at the rising edge
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) plane_reg[i] = '0;
         verdict_q.delete();
      end else begin
         // box beat: predict with the planes in force before this edge
         if (start && !busy) begin
            verdict_q.push_back(cull_verdict(longint'(req_box_min_x),
                                             longint'(req_box_min_y),
                                             longint'(req_box_min_z),
                                             longint'(req_box_max_x),
                                             longint'(req_box_max_y),
                                             longint'(req_box_max_z)));
         end
         // plane write, stray indexes are dropped
         if (csr_write_en && csr_index < PLANE_COUNT)
            plane_reg[csr_index] = csr_write_data;
         // verdict beat
         if (rsp_valid) begin
            got = '{touches: rsp_touches_view, in_all: rsp_fully_inside, ok: rsp_box_ok};
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict beat with nothing outstanding, got t/i/ok=%b%b%b",
                        $time, got.touches, got.in_all, got.ok);
               failures++;
            end else begin
               want = verdict_q.pop_front();
               checked++;
               if (!want.touches) culled++;
               if (want.in_all) contained++;
               if (got.touches !== want.touches || got.in_all !== want.in_all ||
                   got.ok !== want.ok) begin
                  $display("%0t: verdict mismatch, expected t/i/ok=%b%b%b, actual %b%b%b",
                           $time, want.touches, want.in_all, want.ok,
                           got.touches, got.in_all, got.ok);
                  failures++;
               end
            end
         end
      end
      pending = verdict_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives boxes and plane settings into the six-plane culling core: reset
// planes, an axis-aligned cube frustum with exact boundary boxes, a zero
// normal in the middle of the plane order, extreme planes, then random
// plane sets with mostly well-formed boxes. Verdicts are checked by
// cull_checker.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W     = aftc_pkg::DEFAULT_COORD_BITS;
   localparam int NF_W        = aftc_pkg::NFIELD_BITS;
   localparam int DF_W        = aftc_pkg::DFIELD_BITS;
   localparam int IDX_W       = aftc_pkg::CSR_IDX_W;
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 60000;
   localparam int NUM_SETS    = 9;
   localparam int SET_BEATS   = 61;
   localparam int CALM_BEATS  = 80;

   localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_W - 1));
   localparam int N_MAX     = 2 ** (aftc_pkg::NFIELD_BITS - 1) - 1;
   localparam int N_MIN     = -(2 ** (aftc_pkg::NFIELD_BITS - 1));
   localparam int N_ONE     = 2 ** aftc_pkg::DEFAULT_NORMAL_FRAC_BITS;
   localparam int D_MAX     = 2 ** (aftc_pkg::DFIELD_BITS - 1) - 1;
   localparam int D_MIN     = -(2 ** (aftc_pkg::DFIELD_BITS - 1));
   localparam int UNIT      = 256;
   localparam int HALF_W    = 100 * UNIT;

   typedef enum int {
      PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
   } plane_idx_type;

   typedef enum int {SET_FRUSTUM, SET_HOLE, SET_RAW, SET_EXTREME} set_kind_type;

   typedef enum int {SHAPE_RAW, SHAPE_INVERTED, SHAPE_FLAT, SHAPE_WIDE, SHAPE_SMALL}
      box_shape_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] lo;
      logic [2:0][COORD_W-1:0] hi;
   } box_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic signed [COORD_W-1:0]             req_box_min_x, req_box_min_y, req_box_min_z;
   logic signed [COORD_W-1:0]             req_box_max_x, req_box_max_y, req_box_max_z;
   logic                                  rsp_valid, rsp_touches_view;
   logic                                  rsp_fully_inside, rsp_box_ok;
   logic                                  csr_write_en;
   logic [aftc_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [aftc_pkg::CSR_DATA_W-1:0]       csr_write_data;

   int pending, failures, checked, culled, contained;
   int n_boxes, n_settings, cycle_count;

   logic [aftc_pkg::CSR_DATA_W-1:0] plane_set [aftc_pkg::PLANE_COUNT];

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aabb_frustum_cull_test_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_box_min_x    (req_box_min_x),
      .req_box_min_y    (req_box_min_y),
      .req_box_min_z    (req_box_min_z),
      .req_box_max_x    (req_box_max_x),
      .req_box_max_y    (req_box_max_y),
      .req_box_max_z    (req_box_max_z),
      .rsp_valid        (rsp_valid),
      .rsp_touches_view (rsp_touches_view),
      .rsp_fully_inside (rsp_fully_inside),
      .rsp_box_ok       (rsp_box_ok),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cull_checker #(.COORD_W(COORD_W)) verdict_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_box_min_x    (req_box_min_x),
      .req_box_min_y    (req_box_min_y),
      .req_box_min_z    (req_box_min_z),
      .req_box_max_x    (req_box_max_x),
      .req_box_max_y    (req_box_max_y),
      .req_box_max_z    (req_box_max_z),
      .rsp_valid        (rsp_valid),
      .rsp_touches_view (rsp_touches_view),
      .rsp_fully_inside (rsp_fully_inside),
      .rsp_box_ok       (rsp_box_ok),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .failures         (failures),
      .checked          (checked),
      .culled           (culled),
      .contained        (contained)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, pending);
         $display("FAIL aabb_frustum_cull_test_core");
         $finish;
      end
   end

   function automatic logic [aftc_pkg::CSR_DATA_W-1:0] plane_word(input int nx, input int ny,
                                                                   input int nz,
                                                                   input int plane_dist);
      aftc_pkg::plane_type p;
      p.nx = NF_W'(nx);
      p.ny = NF_W'(ny);
      p.nz = NF_W'(nz);
      p.d  = DF_W'(plane_dist);
      return p;
   endfunction

   function automatic box_type box_of(input int x0, input int y0, input int z0,
                                      input int x1, input int y1, input int z1);
      box_type b;
      b.lo[0] = COORD_W'(x0); b.lo[1] = COORD_W'(y0); b.lo[2] = COORD_W'(z0);
      b.hi[0] = COORD_W'(x1); b.hi[1] = COORD_W'(y1); b.hi[2] = COORD_W'(z1);
      return b;
   endfunction

   // one normal component: an extreme of its range, zero or one unit
   function automatic int edge_normal();
      case ($urandom_range(0, 3))
         0:       return N_MAX;
         1:       return N_MIN;
         2:       return 0;
         default: return N_ONE;
      endcase
   endfunction

   function automatic logic [aftc_pkg::CSR_DATA_W-1:0] random_plane(input set_kind_type kind);
      int plane_dist;
      case (kind)
         SET_RAW: return {$urandom, $urandom};
         SET_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       plane_dist = D_MAX;
               1:       plane_dist = D_MIN;
               default: plane_dist = 0;
            endcase
            return plane_word(edge_normal(), edge_normal(), edge_normal(), plane_dist);
         end
         // unit-ish normals and a modest distance give a mix of verdicts
         default: return plane_word(int'($urandom_range(0, 2 * N_ONE)) - N_ONE,
                                    int'($urandom_range(0, 2 * N_ONE)) - N_ONE,
                                    int'($urandom_range(0, 2 * N_ONE)) - N_ONE,
                                    int'($urandom_range(0, 300 * UNIT)) - 150 * UNIT);
      endcase
   endfunction

   // mostly well-formed boxes near the origin, some raw noise and inverted axes
   function automatic box_type random_box();
      box_type       b;
      box_shape_type shape;
      int            pick, bad_axis, spread, mid, lo, hi, t;
      pick     = $urandom_range(0, 9);
      shape    = pick == 0 ? SHAPE_RAW : pick == 1 ? SHAPE_INVERTED :
                 pick == 2 ? SHAPE_FLAT : pick == 3 ? SHAPE_WIDE : SHAPE_SMALL;
      bad_axis = $urandom_range(0, 2);
      spread   = (shape == SHAPE_WIDE) ? 150000 : 20000;
      for (int a = 0; a < 3; a++) begin
         if (shape == SHAPE_RAW) begin
            b.lo[a] = COORD_W'($urandom);
            b.hi[a] = COORD_W'($urandom);
         end else begin
            mid = int'($urandom_range(0, 240000)) - 120000;
            lo  = mid - int'($urandom_range(0, spread));
            hi  = mid + int'($urandom_range(0, spread));
            if (shape == SHAPE_FLAT && $urandom_range(0, 1)) hi = lo;
            if (shape == SHAPE_INVERTED && a == bad_axis) begin
               t  = hi;
               hi = lo;
               lo = t + 1;
            end
            b.lo[a] = COORD_W'(lo);
            b.hi[a] = COORD_W'(hi);
         end
      end
      return b;
   endfunction

   // present one box beat, optionally after an idle burst
   task automatic send_box(input box_type b, input bit may_idle);
      int gap;
      gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start         <= 1'b1;
      req_box_min_x <= b.lo[0];
      req_box_min_y <= b.lo[1];
      req_box_min_z <= b.lo[2];
      req_box_max_x <= b.hi[0];
      req_box_max_y <= b.hi[1];
      req_box_max_z <= b.hi[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      n_boxes++;
   endtask

   // stop sending and wait for every verdict plus the pipeline depth
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // write all six planes; with stray set, stray indexes get junk that must be dropped
   task automatic load_planes(input bit stray);
      drain();
      for (int i = 0; i < aftc_pkg::PLANE_COUNT; i++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= IDX_W'(i);
         csr_write_data <= plane_set[i];
         @(negedge clock);
      end
      if (stray) begin
         for (int i = aftc_pkg::PLANE_COUNT; i < 2 ** aftc_pkg::CSR_IDX_W; i++) begin
            csr_write_en   <= 1'b1;
            csr_index      <= IDX_W'(i);
            csr_write_data <= {$urandom, $urandom};
            @(negedge clock);
         end
      end
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   initial begin
      box_type      b;
      box_type      inner;
      set_kind_type kind;
      int           n_random;
      reset          = 1'b1;
      start          = 1'b0;
      req_box_min_x  = '0;
      req_box_min_y  = '0;
      req_box_min_z  = '0;
      req_box_max_x  = '0;
      req_box_max_y  = '0;
      req_box_max_z  = '0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      n_random       = 0;
      inner          = box_of(-10 * UNIT, -10 * UNIT, -10 * UNIT,
                              10 * UNIT, 10 * UNIT, 10 * UNIT);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // planes at reset have zero normals
      send_box(box_of(0, 0, 0, 0, 0, 0), 1'b0);
      send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
      send_box(box_of(1, 0, 0, 0, 0, 0), 1'b0);

      // axis-aligned cube of half width HALF_W
      plane_set[PLANE_LEFT]   = plane_word(N_ONE, 0, 0, HALF_W);
      plane_set[PLANE_RIGHT]  = plane_word(-N_ONE, 0, 0, HALF_W);
      plane_set[PLANE_BOTTOM] = plane_word(0, N_ONE, 0, HALF_W);
      plane_set[PLANE_TOP]    = plane_word(0, -N_ONE, 0, HALF_W);
      plane_set[PLANE_NEAR]   = plane_word(0, 0, N_ONE, HALF_W);
      plane_set[PLANE_FAR]    = plane_word(0, 0, -N_ONE, HALF_W);
      load_planes(1'b1);
      send_box(inner, 1'b0);
      send_box(box_of(0, 0, 0, 0, 0, 0), 1'b0);
      b = inner;
      b.lo[0] = COORD_W'(-150 * UNIT);
      b.hi[0] = '0;
      send_box(b, 1'b0);
      // wholly beyond each of the six planes
      for (int a = 0; a < 3; a++) begin
         for (int sgn = -1; sgn <= 1; sgn += 2) begin
            b = inner;
            b.lo[a] = (sgn > 0) ? COORD_W'(150 * UNIT) : COORD_W'(-200 * UNIT);
            b.hi[a] = (sgn > 0) ? COORD_W'(200 * UNIT) : COORD_W'(-150 * UNIT);
            send_box(b, 1'b0);
         end
      end
      // max face exactly on the left plane: touches, not inside
      b = inner;
      b.lo[0] = COORD_W'(-HALF_W - UNIT);
      b.hi[0] = COORD_W'(-HALF_W);
      send_box(b, 1'b0);
      // both x faces exactly on their planes: still inside
      b = inner;
      b.lo[0] = COORD_W'(-HALF_W);
      b.hi[0] = COORD_W'(HALF_W);
      send_box(b, 1'b0);
      // inverted on each axis, one at the coordinate extremes, then the full coordinate range
      send_box(box_of(0, 1, 0, 0, 0, 0), 1'b0);
      send_box(box_of(0, 0, 1, 0, 0, 0), 1'b0);
      send_box(box_of(COORD_MAX, 0, 0, COORD_MIN, 0, 0), 1'b0);
      send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);

      // zero normal on the near plane, between rejecting planes
      plane_set[PLANE_NEAR] = plane_word(0, 0, 0, HALF_W);
      load_planes(1'b0);
      b = inner;
      b.lo[0] = COORD_W'(-200 * UNIT);
      b.hi[0] = COORD_W'(-150 * UNIT);
      send_box(b, 1'b0);
      b = inner;
      b.lo[2] = COORD_W'(150 * UNIT);
      b.hi[2] = COORD_W'(200 * UNIT);
      send_box(b, 1'b0);
      send_box(inner, 1'b0);

      // extreme normals and distances
      plane_set[PLANE_LEFT]   = plane_word(N_MAX, N_MIN, N_MAX, D_MAX);
      plane_set[PLANE_RIGHT]  = plane_word(N_MIN, N_MAX, N_MIN, D_MIN);
      plane_set[PLANE_BOTTOM] = '1;
      plane_set[PLANE_TOP]    = plane_word(N_MIN, N_MIN, N_MIN, D_MAX);
      plane_set[PLANE_NEAR]   = plane_word(N_MAX, N_MAX, N_MAX, D_MIN);
      plane_set[PLANE_FAR]    = plane_word(N_MAX, 0, N_MIN, D_MAX);
      load_planes(1'b0);
      send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
      send_box(box_of(0, 0, 0, 0, 0, 0), 1'b0);
      send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
      send_box(box_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);

      // random plane sets, each followed by a stream of boxes
      for (int s = 0; s < NUM_SETS; s++) begin
         kind = set_kind_type'(s % 4);
         for (int i = 0; i < aftc_pkg::PLANE_COUNT; i++) plane_set[i] = random_plane(kind);
         if (kind == SET_HOLE)
            plane_set[$urandom_range(0, aftc_pkg::PLANE_COUNT - 1)]
               [3*aftc_pkg::NFIELD_BITS-1:0] = '0;
         load_planes(s == 0);
         for (int k = 0; k < SET_BEATS; k++) begin
            send_box(random_box(), n_random < NUM_SETS * SET_BEATS - CALM_BEATS);
            n_random++;
         end
      end

      drain();
      $display("covered %0d boxes over %0d plane settings, %0d verdicts compared",
               n_boxes, n_settings, checked);
      $display("verdicts seen: %0d culled, %0d fully inside", culled, contained);
      if (failures == 0) begin
         $display("PASS aabb_frustum_cull_test_core");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAIL aabb_frustum_cull_test_core");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/aftc_pkg.sv
src/aftc_box_stage.sv
src/aftc_plane_eval.sv
src/aabb_frustum_cull_test_core.sv
tb/cull_checker.sv
tb/testbench.sv
